>>> design/vit_pkg.sv
package vit_pkg;

  localparam int NUM_DISPLAYS = 4;
  localparam int DW = $clog2(NUM_DISPLAYS);
  localparam logic [63:0] DEFAULT_INTERVAL_US = 64'd16666;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_REQ   = 3'd1;
  localparam logic [2:0] OP_VBI   = 3'd2;
  localparam logic [2:0] OP_POLL  = 3'd3;
  localparam logic [2:0] OP_READY = 3'd4;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_REQUESTED = 2'd1;
  localparam logic [1:0] ST_TRIGGERED = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_INVAL = 2'd1;
  localparam logic [1:0] STS_UNSUP = 2'd2;

  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_CADENCE = 2'd1;
  localparam logic [1:0] REG_QUERY   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word and read the display state
    logic div_start;  // start the fallback divide
    logic finish;     // commit the state and the result word
  } vit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } vit_sts_t;

endpackage

>>> design/vit_if.sv
interface vit_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  display;
  logic [63:0] time_us;
  logic        hw_query_ok;
  logic        hw_vbi_active;
  logic [63:0] hw_vbi_time_us;
  modport source (output valid, op, display, time_us, hw_query_ok, hw_vbi_active,
                  hw_vbi_time_us, input ready);
  modport sink (input valid, op, display, time_us, hw_query_ok, hw_vbi_active,
                hw_vbi_time_us, output ready);
endinterface

interface vit_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        ready_res;
  logic [1:0]  sync_state;
  logic [63:0] interval_us;
  logic [63:0] last_vbi_us;
  modport source (output valid, status, ready_res, sync_state, interval_us, last_vbi_us,
                  input ready);
  modport sink (input valid, status, ready_res, sync_state, interval_us, last_vbi_us,
                output ready);
endinterface

interface vit_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [3:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/vit_ctrl.sv
module vit_ctrl
  import vit_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  vit_sts_t sts,
  output vit_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Sequencer: load, optional divide, commit, hold result until taken.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/vit_div.sv
module vit_div
  import vit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] remainder
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  // Restoring divide, one quotient bit per cycle.
  assign trial = {rem, quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign remainder = rem;

endmodule

>>> design/vit_dp.sv
module vit_dp
  import vit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  vit_cmd_t    cmd,
  output vit_sts_t    sts,
  input  logic [2:0]  op,
  input  logic [7:0]  display,
  input  logic [63:0] time_us,
  input  logic        hw_query_ok,
  input  logic        hw_vbi_active,
  input  logic [63:0] hw_vbi_time_us,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic [1:0]  status,
  output logic        ready_res,
  output logic [1:0]  sync_state,
  output logic [63:0] interval_us,
  output logic [63:0] last_vbi_us
);

  logic [3:0] active_mask, cadence_mask, query_mask;

  logic [1:0]  sync_st [NUM_DISPLAYS];
  logic [63:0] target  [NUM_DISPLAYS];
  logic [63:0] last_vbi[NUM_DISPLAYS];
  logic [63:0] interval[NUM_DISPLAYS];
  logic [31:0] vbi_cnt [NUM_DISPLAYS];
  logic        enabled [NUM_DISPLAYS];

  // Captured word and the selected display's state.
  logic [2:0]  r_op;
  logic        r_valid;
  logic [DW-1:0] r_d;
  logic [63:0] r_now, r_hts;
  logic        r_qok, r_qact;
  logic [1:0]  c_st;
  logic [63:0] c_tgt, c_last, c_iv;
  logic        c_en;
  logic [63:0] r_diff;

  logic        div_done;
  logic [63:0] div_rem;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask  <= '0;
      cadence_mask <= '0;
      query_mask   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE:  active_mask  <= cfg_data;
        REG_CADENCE: cadence_mask <= cfg_data;
        REG_QUERY:   query_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op    <= op;
      r_valid <= (display < 8'(NUM_DISPLAYS));
      r_d     <= display[DW-1:0];
      r_now   <= time_us;
      r_hts   <= hw_vbi_time_us;
      r_qok   <= hw_query_ok;
      r_qact  <= hw_vbi_active;
      c_st    <= sync_st[display[DW-1:0]];
      c_tgt   <= target[display[DW-1:0]];
      c_last  <= last_vbi[display[DW-1:0]];
      c_iv    <= interval[display[DW-1:0]];
      c_en    <= enabled[display[DW-1:0]];
      r_diff  <= time_us - last_vbi[display[DW-1:0]];
    end
  end

  logic act_b, cad_b, qry_b, use_hw, fb_now_ok, fb_hit;
  assign act_b = active_mask[r_d];
  assign cad_b = cadence_mask[r_d];
  assign qry_b = query_mask[r_d];
  assign use_hw = qry_b && r_qok && r_qact;
  assign fb_now_ok = (r_now >= c_last);
  assign fb_hit = (c_last != 64'd0) && (c_iv != 64'd0) && fb_now_ok && (r_diff >= c_iv);
  assign sts.need_div = r_valid && (r_op == OP_POLL) && act_b && !use_hw && fb_hit;
  assign sts.div_done = div_done;

  vit_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (r_diff),
    .divisor   (c_iv),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Synthesized VBI time: the last whole interval before now, which is
  // now minus the remainder of (now - last) / interval.
  logic [63:0] synth_ts;
  assign synth_ts = r_now - div_rem;

  // Next state of the display.
  logic [1:0]  n_st;
  logic [63:0] n_tgt, n_last, n_iv;
  logic [31:0] n_cnt;
  logic        n_en, n_ready;
  logic [1:0]  n_status;
  logic        vbi_do;
  logic [63:0] vbi_ts;
  logic [65:0] wsum;

  always_comb begin
    n_st = c_st; n_tgt = c_tgt; n_last = c_last; n_iv = c_iv;
    n_cnt = vbi_cnt[r_d]; n_en = c_en; n_ready = 1'b0; n_status = STS_OK;
    vbi_do = 1'b0; vbi_ts = r_now;
    if (r_op > OP_READY) begin
      n_status = STS_UNSUP;
    end else if (!r_valid) begin
      n_status = STS_INVAL;
      n_ready = (r_op == OP_READY);
    end else begin
      unique case (r_op)
        OP_INIT: begin
          n_st = ST_IDLE; n_tgt = '0; n_last = '0; n_iv = DEFAULT_INTERVAL_US;
          n_cnt = '0; n_en = 1'b1;
        end
        OP_REQ: begin
          if (!c_en) n_status = STS_UNSUP;
          else begin
            n_tgt = r_now; n_st = ST_REQUESTED;
          end
        end
        OP_VBI: vbi_do = 1'b1;
        OP_POLL: begin
          if (!act_b) n_status = STS_INVAL;
          else if (use_hw) begin
            vbi_do = 1'b1;
            vbi_ts = (r_hts != 64'd0) ? r_hts : r_now;
          end else if (c_last == 64'd0) n_last = r_now;
          else if (fb_hit) begin
            vbi_do = 1'b1;
            vbi_ts = synth_ts;
          end
        end
        default: begin
          if (!cad_b) n_ready = 1'b1;
          else if (c_st == ST_TRIGGERED) begin
            n_st = ST_IDLE; n_ready = 1'b1;
          end else if (c_tgt != 64'd0 && r_now >= c_tgt) begin
            n_st = ST_IDLE; n_ready = 1'b1;
          end else if (c_tgt == 64'd0 && r_now >= c_last) n_ready = 1'b1;
        end
      endcase
    end
    // VBI handling with the exact weighted sum.
    wsum = {2'b0, c_iv} + {2'b0, c_iv} + {2'b0, c_iv} + {2'b0, vbi_ts - c_last};
    if (vbi_do) begin
      if (c_last != 64'd0 && vbi_ts > c_last) n_iv = wsum[65:2];
      n_last = vbi_ts;
      n_cnt = vbi_cnt[r_d] + 32'd1;
      if (c_st == ST_REQUESTED && (c_tgt == 64'd0 || vbi_ts >= c_tgt)) n_st = ST_TRIGGERED;
    end
  end

  // Commit state and the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DISPLAYS; i++) begin
        sync_st[i] <= ST_IDLE; target[i] <= '0; last_vbi[i] <= '0;
        interval[i] <= '0; vbi_cnt[i] <= '0; enabled[i] <= 1'b0;
      end
    end else if (cmd.finish && r_valid) begin
      sync_st[r_d] <= n_st; target[r_d] <= n_tgt; last_vbi[r_d] <= n_last;
      interval[r_d] <= n_iv; vbi_cnt[r_d] <= n_cnt; enabled[r_d] <= n_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= n_status;
      ready_res   <= n_ready;
      sync_state  <= r_valid ? n_st : ST_IDLE;
      interval_us <= r_valid ? n_iv : 64'd0;
      last_vbi_us <= r_valid ? n_last : 64'd0;
    end
  end

endmodule

>>> design/vsync_interval_tracker_core.sv
// Vertical-blank interval tracker for four displays.
// Channels: in_ch carries one event word (op, display, time and the
// backend poll report); out_ch returns one result word per event;
// cfg_ch writes the active, cadence and query-capable masks, and is
// always ready. Configuration must be written only while the block is
// idle; the user must keep to this, the block itself does not enforce it.
// Without a divide, an accepted event is loaded, evaluated in S_EVAL, and
// its result word is registered and offered on out_ch. A fallback poll
// that synthesizes a VBI first runs the restoring divider in S_DIV, then
// commits its result.
// The block handles one event at a time; in_ch.ready is high only when
// no event is in flight.
// The result word is held in an output register while the receiver
// stalls, and no new event is taken until it is accepted.
// Reset (rst, synchronous) clears the masks and all per-display state.
module vsync_interval_tracker_core
  import vit_pkg::*;
(
  input logic clk,
  input logic rst,
  vit_in_if.sink    in_ch,
  vit_out_if.source out_ch,
  vit_cfg_if.sink   cfg_ch
);

  vit_cmd_t cmd;
  vit_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  vit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vit_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .op             (in_ch.op),
    .display        (in_ch.display),
    .time_us        (in_ch.time_us),
    .hw_query_ok    (in_ch.hw_query_ok),
    .hw_vbi_active  (in_ch.hw_vbi_active),
    .hw_vbi_time_us (in_ch.hw_vbi_time_us),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .status         (out_ch.status),
    .ready_res      (out_ch.ready_res),
    .sync_state     (out_ch.sync_state),
    .interval_us    (out_ch.interval_us),
    .last_vbi_us    (out_ch.last_vbi_us)
  );

`ifndef NO_ASSERTIONS
  // An accepted event always leads to a result before the next is taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  // A result never appears in the cycle right after acceptance.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("result too early");
  // Divide starts only after an event is loaded.
  a_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> $past(cmd.load)) else $error("divide without load");
`endif

endmodule
